/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Every property is sampled on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property with an implication or a sequence.
`define JST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("jst assertion failed");

// Plain invariant that must hold at every clock edge.
`define JST_INVARIANT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("jst invariant failed");

`endif

/* hdl/jst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jst_pkg
// Types and codes of the streaming JSON tokenizer.
// ----------------------------------------------------------------------------
package jst_pkg;

  typedef enum logic [3:0] {
    ST_VALUE, ST_SEEK_NEXT, ST_SEEK_COLON, ST_STR, ST_ESC, ST_UNI, ST_NUM,
    ST_INT_TOP, ST_INT, ST_AFTER_INT, ST_FRAC, ST_AFTER_FRAC, ST_EXP_SIGN,
    ST_EXP_TOP, ST_EXP, ST_SYM
  } pstate_e;

  typedef enum logic [1:0] {
    CTX_ARRAY  = 2'd0,
    CTX_NAME   = 2'd1,
    CTX_OBJVAL = 2'd2
  } ctx_e;

  localparam logic [3:0] EV_OBJSTART = 4'd0;
  localparam logic [3:0] EV_OBJEND   = 4'd1;
  localparam logic [3:0] EV_ARRSTART = 4'd2;
  localparam logic [3:0] EV_ARREND   = 4'd3;
  localparam logic [3:0] EV_NAMEBYTE = 4'd4;
  localparam logic [3:0] EV_NAMEEND  = 4'd5;
  localparam logic [3:0] EV_STRBYTE  = 4'd6;
  localparam logic [3:0] EV_STREND   = 4'd7;
  localparam logic [3:0] EV_NUMBYTE  = 4'd8;
  localparam logic [3:0] EV_NUMEND   = 4'd9;
  localparam logic [3:0] EV_SYMBYTE  = 4'd10;
  localparam logic [3:0] EV_SYMEND   = 4'd11;
  localparam logic [3:0] EV_ERROR    = 4'd12;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_NAME      = 4'd1;
  localparam logic [3:0] ERR_OVERFLOW  = 4'd2;
  localparam logic [3:0] ERR_BRACE     = 4'd3;
  localparam logic [3:0] ERR_BRACKET   = 4'd4;
  localparam logic [3:0] ERR_AFTER_VAL = 4'd5;
  localparam logic [3:0] ERR_COLON     = 4'd6;
  localparam logic [3:0] ERR_ESCAPE    = 4'd7;
  localparam logic [3:0] ERR_UNICODE   = 4'd8;
  localparam logic [3:0] ERR_NUMBER    = 4'd9;
  localparam logic [3:0] ERR_EXPONENT  = 4'd10;
  localparam logic [3:0] ERR_TOKEN     = 4'd11;

  localparam int unsigned MaxEvents = 4;

  // One token event, without the line number and last flag.
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] tbyte;
    logic       named;
    logic [5:0] depth;
    logic [3:0] err;
  } event_t;

  // All events caused by one input byte.
  typedef struct packed {
    event_t [MaxEvents-1:0] ev;
    logic [2:0]             count;
    logic [15:0]            line;
  } bundle_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic event_t mk_event(logic [3:0] k, logic [7:0] b, logic nm,
                                      logic [5:0] dp, logic [3:0] e);
    event_t r;
    r.kind  = k;
    r.tbyte = b;
    r.named = nm;
    r.depth = dp;
    r.err   = e;
    return r;
  endfunction

endpackage

/* hdl/jst_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jst_front
// Accepts text bytes, runs the tokenizer state machine for one byte per
// cycle while the queue is not full and hands the resulting event bundle to the queue.
// ----------------------------------------------------------------------------
module jst_front import jst_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned TOKEN_LEN   = 256
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    in_mode_i,
  input  logic [7:0] in_byte_i,
  input  logic    cfg_valid_i,
  input  logic    cfg_data_i,
  input  qstat_t  qstat_i,
  output logic    push_o,
  output bundle_t push_data_o
);

  localparam int unsigned PW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned TW = $clog2(TOKEN_LEN);
  localparam logic [PW-1:0] PtrMax  = PW'(STACK_DEPTH);
  localparam logic [TW-1:0] TokLast = TW'(TOKEN_LEN - 1);

  // Architectural state.
  pstate_e         st_q, st_d;
  ctx_e            ctx_q, ctx_d;
  logic [PW-1:0]   ptr_q, ptr_d;
  logic [TW-1:0]   tl_q, tl_d;
  logic [2:0]      hc_q, hc_d;
  logic [15:0]     esc_q, esc_d;
  logic [15:0]     nl_q, nl_d;
  logic            er_q, er_d;
  logic            strict_q;
  logic            stk_q [STACK_DEPTH];
  logic            stk_nxt;

  // Step results.
  event_t [MaxEvents-1:0] ev;
  logic [2:0]  n;
  logic        pushed, popped, pkind;
  logic        accept;

  // Scratch for one pass of the dispatch loop.
  logic        again, go, tk, ad, ast, nm, hex;
  logic [3:0]  ak, d;
  pstate_e     anx;
  logic [7:0]  ab, c, b;
  logic [7:0]  ub [3];
  logic [1:0]  nb;

  assign c      = in_byte_i;
  assign accept = in_valid_i && in_ready_o;

  if (STACK_DEPTH > 1) begin : g_nxt
    assign stk_nxt = stk_q[1];
  end else begin : g_nonxt
    assign stk_nxt = 1'b0;
  end

  // Next-state logic: up to eight dispatch passes over one byte.
  always_comb begin
    st_d = st_q; ctx_d = ctx_q; ptr_d = ptr_q; tl_d = tl_q;
    hc_d = hc_q; esc_d = esc_q; er_d = er_q;
    ev = '0; n = '0; pushed = 1'b0; popped = 1'b0; pkind = 1'b0;
    again = 1'b0; go = 1'b1; tk = 1'b0; ad = 1'b0; ast = 1'b0; nm = 1'b0;
    hex = 1'b0; ak = '0; d = '0; anx = ST_VALUE; ab = '0; b = '0; nb = '0;
    ub[0] = '0; ub[1] = '0; ub[2] = '0;
    for (int i = 0; i < 8; i++) begin
      if (go && !er_d) begin
        again = 1'b0;
        ad = 1'b0;
        ast = 1'b0;
        nm = (ctx_d == CTX_OBJVAL);
        tk = popped ? stk_nxt : stk_q[0];
        unique case (st_d)
          ST_VALUE: begin
            if (c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d) begin
            end else if (c == 8'h22) begin
              tl_d = '0; st_d = ST_STR;
            end else if (c == 8'h2d || (c >= 8'h30 && c <= 8'h39)) begin
              if (ctx_d == CTX_NAME) begin
                ev[n[1:0]] = mk_event(EV_ERROR, '0, 1'b0, 6'(ptr_d), ERR_NAME);
                n = n + 3'd1; er_d = 1'b1;
              end else begin
                tl_d = '0; st_d = ST_NUM; again = 1'b1;
              end
            end else if (c == 8'h7b || c == 8'h5b) begin
              if (ctx_d == CTX_NAME) begin
                ev[n[1:0]] = mk_event(EV_ERROR, '0, 1'b0, 6'(ptr_d), ERR_NAME);
                n = n + 3'd1; er_d = 1'b1;
              end else if (ptr_d >= PtrMax) begin
                ev[n[1:0]] = mk_event(EV_ERROR, '0, 1'b0, 6'(ptr_d), ERR_OVERFLOW);
                n = n + 3'd1; er_d = 1'b1;
              end else begin
                pushed = 1'b1; pkind = (c == 8'h7b); ptr_d = ptr_d + 1'b1;
                ev[n[1:0]] = mk_event(pkind ? EV_OBJSTART : EV_ARRSTART, '0, nm,
                                      6'(ptr_d), ERR_NONE);
                n = n + 3'd1;
                ctx_d = pkind ? CTX_NAME : CTX_ARRAY;
              end
            end else if (c == 8'h7d || c == 8'h5d) begin
              if (ptr_d != '0 && (tk == (c == 8'h7d))) begin
                ptr_d = ptr_d - 1'b1; popped = 1'b1;
                ev[n[1:0]] = mk_event((c == 8'h7d) ? EV_OBJEND : EV_ARREND, '0, 1'b0,
                                      6'(ptr_d), ERR_NONE);
                n = n + 3'd1;
                ctx_d = (ptr_d != '0 && stk_nxt) ? CTX_OBJVAL : CTX_ARRAY;
                st_d = ST_SEEK_NEXT;
              end else begin
                ev[n[1:0]] = mk_event(EV_ERROR, '0, 1'b0, 6'(ptr_d),
                                      (c == 8'h7d) ? ERR_BRACE : ERR_BRACKET);
                n = n + 3'd1; er_d = 1'b1;
              end
            end else if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a)
                         || c == 8'h5f) begin
              if (ctx_d == CTX_NAME) begin
                ev[n[1:0]] = mk_event(EV_ERROR, '0, 1'b0, 6'(ptr_d), ERR_NAME);
                n = n + 3'd1; er_d = 1'b1;
              end else begin
                tl_d = '0; ad = 1'b1; ak = EV_SYMBYTE; ab = c; ast = 1'b1;
                anx = ST_SYM;
              end
            end
          end
          ST_SEEK_NEXT: begin
            if (c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d) begin
            end else if (c == 8'h2c) begin
              ctx_d = (ctx_d == CTX_OBJVAL) ? CTX_NAME : CTX_ARRAY;
              st_d = ST_VALUE;
            end else if (c == 8'h7d || c == 8'h5d) begin
              st_d = ST_VALUE; again = 1'b1;
            end else begin
              ev[n[1:0]] = mk_event(EV_ERROR, '0, 1'b0, 6'(ptr_d), ERR_AFTER_VAL);
              n = n + 3'd1; er_d = 1'b1;
            end
          end
          ST_SEEK_COLON: begin
            if (c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d) begin
            end else if (c == 8'h3a) begin
              ctx_d = CTX_OBJVAL; st_d = ST_VALUE;
            end else begin
              ev[n[1:0]] = mk_event(EV_ERROR, '0, 1'b0, 6'(ptr_d), ERR_COLON);
              n = n + 3'd1; er_d = 1'b1;
            end
          end
          ST_STR: begin
            if (c == 8'h5c) begin
              st_d = ST_ESC;
            end else if (c == 8'h22) begin
              if (ctx_d == CTX_NAME) begin
                ev[n[1:0]] = mk_event(EV_NAMEEND, '0, 1'b0, 6'(ptr_d), ERR_NONE);
                st_d = ST_SEEK_COLON;
              end else begin
                ev[n[1:0]] = mk_event(EV_STREND, '0, nm, 6'(ptr_d), ERR_NONE);
                st_d = ST_SEEK_NEXT;
              end
              n = n + 3'd1;
            end else begin
              ad = 1'b1; ab = c;
              ak = (ctx_d == CTX_NAME) ? EV_NAMEBYTE : EV_STRBYTE;
            end
          end
          ST_ESC: begin
            case (c)
              8'h62:   b = 8'h08;
              8'h66:   b = 8'h0c;
              8'h6e:   b = 8'h0a;
              8'h72:   b = 8'h0d;
              8'h74:   b = 8'h09;
              default: b = c;
            endcase
            if (c == 8'h75) begin
              hc_d = '0; esc_d = '0; st_d = ST_UNI;
            end else if (c == 8'h22 || c == 8'h5c || c == 8'h2f || b != c
                         || !strict_q) begin
              ad = 1'b1; ab = b; ast = 1'b1; anx = ST_STR;
              ak = (ctx_d == CTX_NAME) ? EV_NAMEBYTE : EV_STRBYTE;
            end else begin
              ev[n[1:0]] = mk_event(EV_ERROR, '0, 1'b0, 6'(ptr_d), ERR_ESCAPE);
              n = n + 3'd1; er_d = 1'b1;
            end
          end
          ST_UNI: begin
            hex = 1'b1;
            if (c >= 8'h30 && c <= 8'h39) d = c[3:0];
            else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
              d = c[3:0] + 4'd9;
            else hex = 1'b0;
            if (hex) begin
              esc_d = {esc_d[11:0], d}; hc_d = hc_d + 3'd1;
            end else if (strict_q) begin
              ev[n[1:0]] = mk_event(EV_ERROR, '0, 1'b0, 6'(ptr_d), ERR_UNICODE);
              n = n + 3'd1; er_d = 1'b1;
            end else begin
              st_d = ST_STR; again = 1'b1;
            end
            if (!er_d && hc_d == 3'd4) begin
              ak = (ctx_d == CTX_NAME) ? EV_NAMEBYTE : EV_STRBYTE;
              if (esc_d <= 16'h007f) begin
                nb = 2'd1; ub[0] = esc_d[7:0];
              end else if (esc_d <= 16'h07ff) begin
                nb = 2'd2; ub[0] = {3'b110, esc_d[10:6]}; ub[1] = {2'b10, esc_d[5:0]};
              end else begin
                nb = 2'd3; ub[0] = {4'b1110, esc_d[15:12]};
                ub[1] = {2'b10, esc_d[11:6]}; ub[2] = {2'b10, esc_d[5:0]};
              end
              for (int j = 0; j < 3; j++) begin
                if (j < int'(nb) && !er_d) begin
                  if (tl_d >= TokLast) begin
                    ev[n[1:0]] = mk_event(EV_ERROR, '0, 1'b0, 6'(ptr_d), ERR_TOKEN);
                    n = n + 3'd1; er_d = 1'b1;
                  end else begin
                    tl_d = tl_d + 1'b1;
                    if (n != 3'd4) begin
                      ev[n[1:0]] = mk_event(ak, ub[j], (ak == EV_NAMEBYTE) ? 1'b0 : nm,
                                            6'(ptr_d), ERR_NONE);
                      n = n + 3'd1;
                    end
                  end
                end
              end
              if (!er_d) st_d = ST_STR;
            end
          end
          ST_NUM: begin
            if (c == 8'h2d) begin
              ad = 1'b1; ak = EV_NUMBYTE; ab = c; ast = 1'b1; anx = ST_INT_TOP;
            end else begin
              st_d = ST_INT_TOP; again = 1'b1;
            end
          end
          ST_INT_TOP: begin
            if (c >= 8'h30 && c <= 8'h39) begin
              ad = 1'b1; ak = EV_NUMBYTE; ab = c; ast = 1'b1;
              anx = (c == 8'h30) ? ST_AFTER_INT : ST_INT;
            end else begin
              ev[n[1:0]] = mk_event(EV_ERROR, '0, 1'b0, 6'(ptr_d), ERR_NUMBER);
              n = n + 3'd1; er_d = 1'b1;
            end
          end
          ST_INT, ST_FRAC: begin
            if (c >= 8'h30 && c <= 8'h39) begin
              ad = 1'b1; ak = EV_NUMBYTE; ab = c;
            end else begin
              st_d = (st_d == ST_INT) ? ST_AFTER_INT : ST_AFTER_FRAC; again = 1'b1;
            end
          end
          ST_AFTER_INT, ST_AFTER_FRAC: begin
            if (c == 8'h2e && st_d == ST_AFTER_INT) begin
              ad = 1'b1; ak = EV_NUMBYTE; ab = c; ast = 1'b1; anx = ST_FRAC;
            end else if (c == 8'h65 || c == 8'h45) begin
              ad = 1'b1; ak = EV_NUMBYTE; ab = c; ast = 1'b1; anx = ST_EXP_SIGN;
            end else begin
              ev[n[1:0]] = mk_event(EV_NUMEND, '0, nm, 6'(ptr_d), ERR_NONE);
              n = n + 3'd1; st_d = ST_SEEK_NEXT; again = 1'b1;
            end
          end
          ST_EXP_SIGN: begin
            if (c == 8'h2b || c == 8'h2d) begin
              ad = 1'b1; ak = EV_NUMBYTE; ab = c; ast = 1'b1; anx = ST_EXP_TOP;
            end else begin
              st_d = ST_EXP_TOP; again = 1'b1;
            end
          end
          ST_EXP_TOP: begin
            if (c >= 8'h30 && c <= 8'h39) begin
              ad = 1'b1; ak = EV_NUMBYTE; ab = c; ast = 1'b1; anx = ST_EXP;
            end else begin
              ev[n[1:0]] = mk_event(EV_ERROR, '0, 1'b0, 6'(ptr_d), ERR_EXPONENT);
              n = n + 3'd1; er_d = 1'b1;
            end
          end
          ST_EXP: begin
            if (c >= 8'h30 && c <= 8'h39) begin
              ad = 1'b1; ak = EV_NUMBYTE; ab = c;
            end else begin
              ev[n[1:0]] = mk_event(EV_NUMEND, '0, nm, 6'(ptr_d), ERR_NONE);
              n = n + 3'd1; st_d = ST_SEEK_NEXT; again = 1'b1;
            end
          end
          ST_SYM: begin
            if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a)
                || (c >= 8'h30 && c <= 8'h39) || c == 8'h5f) begin
              ad = 1'b1; ak = EV_SYMBYTE; ab = c;
            end else begin
              ev[n[1:0]] = mk_event(EV_SYMEND, '0, nm, 6'(ptr_d), ERR_NONE);
              n = n + 3'd1; st_d = ST_SEEK_NEXT; again = 1'b1;
            end
          end
          default: st_d = ST_VALUE;
        endcase
        // Shared token append: checks the token buffer, then emits the byte.
        if (ad) begin
          if (tl_d >= TokLast) begin
            ev[n[1:0]] = mk_event(EV_ERROR, '0, 1'b0, 6'(ptr_d), ERR_TOKEN);
            n = n + 3'd1; er_d = 1'b1;
          end else begin
            tl_d = tl_d + 1'b1;
            if (n != 3'd4) begin
              ev[n[1:0]] = mk_event(ak, ab, (ak == EV_NAMEBYTE) ? 1'b0 : nm,
                                    6'(ptr_d), ERR_NONE);
              n = n + 3'd1;
            end
            if (ast) st_d = anx;
          end
        end
        go = again;
      end
    end
    // Newlines are counted only while no error is pending.
    nl_d = (!er_d && c == 8'h0a && nl_q != 16'hffff) ? nl_q + 16'd1 : nl_q;
  end

  // Handshake and queue write.
  always_comb begin
    in_ready_o         = !qstat_i.full;
    push_o             = accept && !in_mode_i && !er_q && (n != 3'd0);
    push_data_o.ev     = ev;
    push_data_o.count  = n;
    push_data_o.line   = nl_q;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_VALUE; ctx_q <= CTX_ARRAY; ptr_q <= '0; tl_q <= '0;
      hc_q <= '0; esc_q <= '0; nl_q <= '0; er_q <= 1'b0; strict_q <= 1'b0;
    end else begin
      if (cfg_valid_i) strict_q <= cfg_data_i;
      if (accept) begin
        if (in_mode_i) begin
          st_q <= ST_VALUE; ctx_q <= CTX_ARRAY; ptr_q <= '0; tl_q <= '0;
          hc_q <= '0; esc_q <= '0; nl_q <= '0; er_q <= 1'b0;
        end else if (!er_q) begin
          st_q <= st_d; ctx_q <= ctx_d; ptr_q <= ptr_d; tl_q <= tl_d;
          hc_q <= hc_d; esc_q <= esc_d; nl_q <= nl_d; er_q <= er_d;
        end
      end
    end
  end

  // Nesting stack as a shift line: entry zero is the top.
  always_ff @(posedge clk_i) begin
    if (accept && !in_mode_i && !er_q) begin
      if (pushed) begin
        stk_q[0] <= pkind;
        for (int k = 1; k < STACK_DEPTH; k++) stk_q[k] <= stk_q[k-1];
      end else if (popped) begin
        for (int k = 0; k < STACK_DEPTH - 1; k++) stk_q[k] <= stk_q[k+1];
      end
    end
  end

endmodule

/* hdl/jst_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jst_queue
// Two-entry queue of event bundles between the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module jst_queue import jst_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  input  logic    pop_i,
  output bundle_t head_o,
  output qstat_t  qstat_o
);

  bundle_t     mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;

  assign head_o        = mem_q[rp_q];
  assign qstat_o.full  = (cnt_q == 2'd2);
  assign qstat_o.empty = (cnt_q == 2'd0);

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  `JST_INVARIANT(a_cnt_range, cnt_q != 2'd3)
  `JST_ASSERT(a_no_pop_empty, pop_i |-> cnt_q != 2'd0)
  `JST_ASSERT(a_push_grows, (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 2'd1)

endmodule

/* hdl/jst_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jst_back
// Walks the head bundle of the queue and delivers one event per cycle while the output is ready.
// ----------------------------------------------------------------------------
module jst_back import jst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bundle_t    head_i,
  input  qstat_t     qstat_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output event_t     out_event_o,
  output logic [15:0] out_line_o,
  output logic       out_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       fire;

  // Event selection and request completion.
  always_comb begin
    out_valid_o = !qstat_i.empty;
    out_event_o = head_i.ev[idx_q];
    out_line_o  = head_i.line;
    out_last_o  = ({1'b0, idx_q} == head_i.count - 3'd1);
    fire        = out_valid_o && out_ready_i;
    pop_o       = fire && out_last_o;
    idx_d       = idx_q;
    if (fire) idx_d = out_last_o ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

/* hdl/json_stream_tokenizer.sv */
// The events of a byte are registered in the bundle queue before they are offered.
// Throughput: one byte per cycle while each byte yields at most one event and the
// output is ready; the back part delivers the events of a byte one after another.
// The front stalls only when the two-entry bundle queue is full.
// Reset (rst_ni low, asynchronous) clears parse state, counters and strict mode.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_stream_tokenizer
// Streaming JSON tokenizer: text bytes in, token events out.
// ----------------------------------------------------------------------------
module json_stream_tokenizer import jst_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned TOKEN_LEN   = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] token_byte, [8] named_value, [14:9] nest_depth, [18:15] error_code,
  // [34:19] line_number, [39:35] zero
  output logic [39:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,   // [3:0] event_kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  qstat_t     qstat;
  logic       push, pop;
  bundle_t    push_data, head;
  event_t     ev;
  logic [15:0] line;

  assign cfg_ready_o = 1'b1;

  jst_front #(.STACK_DEPTH(STACK_DEPTH), .TOKEN_LEN(TOKEN_LEN)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_mode_i(s_axis_tuser), .in_byte_i(s_axis_tdata),
    .cfg_valid_i, .cfg_data_i,
    .qstat_i(qstat), .push_o(push), .push_data_o(push_data)
  );

  jst_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data),
    .pop_i(pop), .head_o(head), .qstat_o(qstat)
  );

  jst_back u_back (
    .clk_i, .rst_ni, .head_i(head), .qstat_i(qstat), .pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_event_o(ev), .out_line_o(line), .out_last_o(m_axis_tlast)
  );

  // Output packing.
  assign m_axis_tuser = ev.kind;
  assign m_axis_tdata = {5'd0, line, ev.err, ev.depth, ev.named, ev.tbyte};

endmodule
